// ===== hw/rtl/stdm_pkg.sv =====
`timescale 1ns / 1ps

package stdm_pkg;

	// payload widths
	localparam int SAMPLE_W = 12;
	localparam int MIX_W    = 12;
	localparam int LED_W    = 6;

	// default sizing
	localparam int DELAY_DEPTH_DEF = 1024;
	localparam int LAMP_PERIOD_DEF = 12000;
	localparam int REFRESH_W       = 14;

	// mode codes
	localparam logic [1:0] MODE_SHORT = 2'd0;
	localparam logic [1:0] MODE_MID   = 2'd1;
	localparam logic [1:0] MODE_LONG  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// tap lengths
	localparam int          TAP_W     = 9;
	localparam logic [8:0]  TAP_SHORT = 9'd80;
	localparam logic [8:0]  TAP_MID   = 9'd120;
	localparam logic [8:0]  TAP_LONG  = 9'd300;

	// crossfade and saturation
	localparam logic [12:0]        MIX_FULL = 13'd4095;
	localparam logic signed [12:0] SAT_MAX  = 13'sd2047;
	localparam logic signed [12:0] SAT_MIN  = -13'sd2048;

	// lamp thresholds and bits
	localparam logic [11:0] MIX_LOW_LIM  = 12'd1024;
	localparam logic [11:0] MIX_HIGH_LIM = 12'd3071;
	localparam logic [11:0] MIX_WET_LIM  = 12'd2000;
	localparam logic [5:0]  LAMP_SHORT   = 6'b000001;
	localparam logic [5:0]  LAMP_MID     = 6'b000010;
	localparam logic [5:0]  LAMP_LONG    = 6'b000100;
	localparam logic [5:0]  LAMP_WET     = 6'b001000;
	localparam logic [5:0]  LAMP_LOW     = 6'b010000;
	localparam logic [5:0]  LAMP_HIGH    = 6'b100000;

endpackage

// ===== hw/rtl/stdm_in_if.sv =====
`timescale 1ns / 1ps

interface stdm_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [stdm_pkg::SAMPLE_W-1:0] sample_in;
	logic        [stdm_pkg::MIX_W-1:0]    mix_level;
	logic                                  switch_down;

	modport source (output valid, output sample_in, output mix_level, output switch_down,
		input ready);
	modport sink (input valid, input sample_in, input mix_level, input switch_down,
		output ready);
endinterface

// ===== hw/rtl/stdm_out_if.sv =====
`timescale 1ns / 1ps

interface stdm_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [stdm_pkg::SAMPLE_W-1:0] sample_out;
	logic        [stdm_pkg::LED_W-1:0]    led_mask;

	modport source (output valid, output sample_out, output led_mask, input ready);
	modport sink (input valid, input sample_out, input led_mask, output ready);
endinterface

// ===== hw/rtl/selectable_tap_delay_mixer.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                                  | handshake
// din     | in  | sample_in[12]s, mix_level[12], switch_down | valid/ready
// dout    | out | sample_out[12]s, led_mask[6]              | valid/ready
//
// One item per cycle while dout takes results; each result, after its transfer, passes
// through five registers (memory read, products, sum, magnitude, quotient and clamp).
// Reset clears all control state; the delay memory itself is not cleared, a
// saturating fill count reads taps not yet written as zero.
// All stages stall together while a finished result waits on dout.

module selectable_tap_delay_mixer #(
	parameter int DELAY_DEPTH = stdm_pkg::DELAY_DEPTH_DEF,
	parameter int LAMP_PERIOD = stdm_pkg::LAMP_PERIOD_DEF
) (
	input logic        clk,
	input logic        arst_n,
	stdm_in_if.sink    din,
	stdm_out_if.source dout
);

	localparam int AW  = $clog2(DELAY_DEPTH);
	localparam int AWX = AW + 1;

	logic advance, accept;

	// block state
	logic [AW-1:0]                   wp_q, wp_next, rp;
	logic [AWX-1:0]                  rp_ext, wp_ext, tap_ext;
	logic [1:0]                      mode_q, mode_next;
	logic                            prev_sw_q;
	logic [stdm_pkg::REFRESH_W-1:0]  refresh_q, refresh_inc;
	logic [stdm_pkg::LED_W-1:0]      lamp_q, lamp_sticky, lamp_next, lamp_mode;
	logic [stdm_pkg::TAP_W-1:0]      fill_q, tap;

	// pipeline
	logic                            v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic signed [11:0]              dry_s1, wet_s1, wet_eff;
	logic [11:0]                     mix_s1;
	logic                            wet_ok_s1;
	logic [5:0]                      led_s1, led_s2, led_s3, led_s4, led_q;
	logic signed [12:0]              wt_dry;
	logic signed [24:0]              prod_dry_s2, prod_wet_s2;
	logic signed [25:0]              sum_s3, mag_full;
	logic                            neg_s4;
	logic [22:0]                     mag_s4;
	logic [23:0]                     qsum;
	logic [11:0]                     quot;
	logic signed [12:0]              res;
	logic signed [11:0]              sample_q;

	logic [11:0] mem [DELAY_DEPTH];

	assign advance  = !out_valid_q || dout.ready;
	assign din.ready = advance;
	assign accept   = din.valid && advance;

	// mode and tap for this item
	always_comb begin
		mode_next = mode_q;
		if (din.switch_down && !prev_sw_q) begin
			if (mode_q == stdm_pkg::MODE_LONG || mode_q == stdm_pkg::MODE_SPARE)
				mode_next = stdm_pkg::MODE_SHORT;
			else
				mode_next = mode_q + 2'd1;
		end
		case (mode_next)
			stdm_pkg::MODE_MID:  tap = stdm_pkg::TAP_MID;
			stdm_pkg::MODE_LONG: tap = stdm_pkg::TAP_LONG;
			default:             tap = stdm_pkg::TAP_SHORT;
		endcase
		case (mode_next)
			stdm_pkg::MODE_SHORT: lamp_mode = stdm_pkg::LAMP_SHORT;
			stdm_pkg::MODE_MID:   lamp_mode = stdm_pkg::LAMP_MID;
			stdm_pkg::MODE_LONG:  lamp_mode = stdm_pkg::LAMP_LONG;
			default:              lamp_mode = '0;
		endcase
	end

	// read address wraps around the circular store
	always_comb begin
		wp_ext  = {1'b0, wp_q};
		tap_ext = AWX'(tap);
		if (wp_ext >= tap_ext)
			rp_ext = wp_ext - tap_ext;
		else
			rp_ext = wp_ext + AWX'(DELAY_DEPTH) - tap_ext;
		rp = rp_ext[AW-1:0];
		wp_next = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	end

	// lamps: sticky knob bits, periodic rebuild
	always_comb begin
		lamp_sticky = lamp_q;
		if (din.mix_level < stdm_pkg::MIX_LOW_LIM)
			lamp_sticky = lamp_sticky | stdm_pkg::LAMP_LOW;
		else if (din.mix_level > stdm_pkg::MIX_HIGH_LIM)
			lamp_sticky = lamp_sticky | stdm_pkg::LAMP_HIGH;
		refresh_inc = refresh_q + stdm_pkg::REFRESH_W'(1);
		lamp_next   = lamp_sticky;
		if (refresh_inc >= stdm_pkg::REFRESH_W'(LAMP_PERIOD)) begin
			lamp_next = lamp_mode;
			if (din.mix_level > stdm_pkg::MIX_WET_LIM)
				lamp_next = lamp_next | stdm_pkg::LAMP_WET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			mode_q    <= stdm_pkg::MODE_SHORT;
			prev_sw_q <= 1'b0;
			refresh_q <= '0;
			lamp_q    <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			wp_q      <= wp_next;
			mode_q    <= mode_next;
			prev_sw_q <= din.switch_down;
			lamp_q    <= lamp_next;
			if (refresh_inc >= stdm_pkg::REFRESH_W'(LAMP_PERIOD))
				refresh_q <= '0;
			else
				refresh_q <= refresh_inc;
			if (fill_q < stdm_pkg::TAP_LONG)
				fill_q <= fill_q + stdm_pkg::TAP_W'(1);
		end
	end

	// delay memory: one write, one registered read per transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wp_q] <= din.sample_in;
			wet_s1    <= mem[rp];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= din.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign wt_dry  = $signed(stdm_pkg::MIX_FULL - {1'b0, mix_s1});
	assign wet_eff = wet_ok_s1 ? wet_s1 : '0;

	assign mag_full = sum_s3[25] ? -sum_s3 : sum_s3;

	// |sum| <= 2048*4095, where (m + m/4096 + 1)/4096 is exactly m/4095 rounded down
	always_comb begin
		qsum = {1'b0, mag_s4} + 24'(mag_s4[22:12]) + 24'd1;
		quot = qsum[23:12];
		res  = neg_s4 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		if (res > stdm_pkg::SAT_MAX)
			res = stdm_pkg::SAT_MAX;
		else if (res < stdm_pkg::SAT_MIN)
			res = stdm_pkg::SAT_MIN;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (accept) begin
				dry_s1    <= din.sample_in;
				mix_s1    <= din.mix_level;
				wet_ok_s1 <= (fill_q >= tap);
				led_s1    <= lamp_next;
			end
			prod_dry_s2 <= dry_s1 * wt_dry;
			prod_wet_s2 <= wet_eff * $signed({1'b0, mix_s1});
			led_s2      <= led_s1;
			sum_s3      <= 26'(prod_dry_s2) + 26'(prod_wet_s2);
			led_s3      <= led_s2;
			neg_s4      <= sum_s3[25];
			mag_s4      <= mag_full[22:0];
			led_s4      <= led_s3;
			sample_q    <= res[11:0];
			led_q       <= led_s4;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = sample_q;
	assign dout.led_mask   = led_q;

endmodule

// ===== tb/sv/selectable_tap_delay_mixer_test.sv =====
`timescale 1ns / 1ps

module selectable_tap_delay_mixer_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic signed [stdm_pkg::SAMPLE_W-1:0] sample;
		logic [stdm_pkg::LED_W-1:0]           lamps;
	} mixed_result_t;

	logic clk = 1'b0;
	logic arst_n;

	stdm_in_if  din_ch ();
	stdm_out_if dout_ch ();

	selectable_tap_delay_mixer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	// mixer state as the block should hold it
	logic [stdm_pkg::SAMPLE_W-1:0]  echo_mem [stdm_pkg::DELAY_DEPTH_DEF];
	logic [9:0]                     wr_pos;
	logic [1:0]                     mode_q;
	logic                           switch_q;
	logic [stdm_pkg::REFRESH_W-1:0] refresh_q;
	logic [stdm_pkg::LED_W-1:0]     lamp_q;

	mixed_result_t pending_mixes[$];
	mixed_result_t want;
	int            mismatch_count;
	int            accepted_count;
	int            stall_cycles;
	int            src_idle_pct;
	int            snk_idle_pct;

	always #5 clk = ~clk;

	function automatic logic [stdm_pkg::TAP_W-1:0] tap_of_mode(input logic [1:0] mode);
		case (mode)
			stdm_pkg::MODE_MID:  return stdm_pkg::TAP_MID;
			stdm_pkg::MODE_LONG: return stdm_pkg::TAP_LONG;
			default:             return stdm_pkg::TAP_SHORT;
		endcase
	endfunction

	function automatic mixed_result_t mix_next_sample(
		input logic signed [stdm_pkg::SAMPLE_W-1:0] sample,
		input logic [stdm_pkg::MIX_W-1:0] mix, input logic sw);
		int                                   dry;
		int                                   level;
		int                                   full;
		int                                   wet;
		int                                   acc;
		logic [9:0]                           rd_pos;
		logic signed [stdm_pkg::SAMPLE_W-1:0] wet_s;
		mixed_result_t                        r;
		dry   = sample;
		level = mix;
		full  = int'(stdm_pkg::MIX_FULL);
		if (sw && !switch_q) begin
			mode_q = (mode_q == stdm_pkg::MODE_LONG || mode_q == stdm_pkg::MODE_SPARE) ?
				stdm_pkg::MODE_SHORT : mode_q + 2'd1;
		end
		switch_q = sw;
		if (mix < stdm_pkg::MIX_LOW_LIM) begin
			lamp_q |= stdm_pkg::LAMP_LOW;
		end else if (mix > stdm_pkg::MIX_HIGH_LIM) begin
			lamp_q |= stdm_pkg::LAMP_HIGH;
		end
		echo_mem[wr_pos] = sample;
		rd_pos = wr_pos - 10'(tap_of_mode(mode_q));
		wet_s  = echo_mem[rd_pos];
		wet    = wet_s;
		acc    = (dry * (full - level) + wet * level) / full;
		if (acc > stdm_pkg::SAT_MAX) begin
			acc = stdm_pkg::SAT_MAX;
		end
		if (acc < stdm_pkg::SAT_MIN) begin
			acc = stdm_pkg::SAT_MIN;
		end
		wr_pos    = wr_pos + 10'd1;
		refresh_q = refresh_q + 1'b1;
		if (refresh_q >= stdm_pkg::LAMP_PERIOD_DEF) begin
			refresh_q = '0;
			case (mode_q)
				stdm_pkg::MODE_SHORT: lamp_q = stdm_pkg::LAMP_SHORT;
				stdm_pkg::MODE_MID:   lamp_q = stdm_pkg::LAMP_MID;
				stdm_pkg::MODE_LONG:  lamp_q = stdm_pkg::LAMP_LONG;
				default:              lamp_q = '0;
			endcase
			if (mix > stdm_pkg::MIX_WET_LIM) begin
				lamp_q |= stdm_pkg::LAMP_WET;
			end
		end
		r.sample = acc[stdm_pkg::SAMPLE_W-1:0];
		r.lamps  = lamp_q;
		return r;
	endfunction

	// enter and leave right after a falling edge
	task automatic push_sample(input logic signed [stdm_pkg::SAMPLE_W-1:0] sample,
		input logic [stdm_pkg::MIX_W-1:0] mix, input logic sw);
		while ($urandom_range(99) < src_idle_pct) begin
			din_ch.valid <= 1'b0;
			@(negedge clk);
		end
		din_ch.valid       <= 1'b1;
		din_ch.sample_in   <= sample;
		din_ch.mix_level   <= mix;
		din_ch.switch_down <= sw;
		@(posedge clk);
		while (!din_ch.ready) begin
			@(posedge clk);
		end
		pending_mixes.push_back(mix_next_sample(sample, mix, sw));
		accepted_count++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		din_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_mixes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [stdm_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return 12'h800;
			1:       return 12'h7FF;
			2:       return 12'h000;
			default: return stdm_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [stdm_pkg::MIX_W-1:0] pick_mix(input int mid_pct);
		if ($urandom_range(99) < mid_pct) begin
			return stdm_pkg::MIX_W'($urandom_range(stdm_pkg::MIX_HIGH_LIM,
				stdm_pkg::MIX_LOW_LIM));
		end
		case ($urandom_range(11))
			0:       return '0;
			1:       return '1;
			2:       return stdm_pkg::MIX_LOW_LIM - 1'b1;
			3:       return stdm_pkg::MIX_LOW_LIM;
			4:       return stdm_pkg::MIX_HIGH_LIM;
			5:       return stdm_pkg::MIX_HIGH_LIM + 1'b1;
			6:       return stdm_pkg::MIX_WET_LIM;
			7:       return stdm_pkg::MIX_WET_LIM + 1'b1;
			default: return stdm_pkg::MIX_W'($urandom);
		endcase
	endfunction

	// taps read back as zero right after reset; walk the field extremes,
	// lamp thresholds and every mode change, including the wrap to the short tap
	task automatic test_directed_extremes();
		push_sample(-12'sd2048, 12'd0, 1'b0);
		push_sample(12'sd2047, 12'd4095, 1'b0);
		push_sample(-12'sd2048, 12'd4095, 1'b0);
		push_sample(12'sd2047, 12'd0, 1'b0);
		push_sample(12'sd0, stdm_pkg::MIX_LOW_LIM - 1'b1, 1'b0);
		push_sample(-12'sd1, stdm_pkg::MIX_LOW_LIM, 1'b0);
		push_sample(12'sd1, stdm_pkg::MIX_HIGH_LIM, 1'b0);
		push_sample(12'sd1000, stdm_pkg::MIX_HIGH_LIM + 1'b1, 1'b0);
		push_sample(-12'sd1000, stdm_pkg::MIX_WET_LIM, 1'b0);
		push_sample(12'sd1234, stdm_pkg::MIX_WET_LIM + 1'b1, 1'b0);
		push_sample(12'sd2047, 12'd2048, 1'b1);
		push_sample(-12'sd2048, 12'd2048, 1'b1);
		push_sample(12'sd5, 12'd1, 1'b0);
		push_sample(-12'sd5, 12'd4094, 1'b1);
		push_sample(12'sd2047, 12'd4095, 1'b1);
		push_sample(12'sd0, 12'd0, 1'b0);
		push_sample(-12'sd2048, 12'd4095, 1'b1);
		push_sample(12'sd2047, 12'd2047, 1'b0);
		push_sample(12'sd1365, 12'd3000, 1'b1);
		push_sample(-12'sd1366, 12'd1500, 1'b0);
	endtask

	task automatic test_random_stream(input int n_items, input int src_pct, input int snk_pct);
		logic sw;
		sw           = switch_q;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int i = 0; i < n_items; i++) begin
			// toggle the switch at random, on one item in thirty on average
			if ($urandom_range(29) == 0) begin
				sw = ~sw;
			end
			push_sample(pick_sample(), pick_mix(20), sw);
			if (i == n_items / 2) begin
				hold_until_drained();
			end
		end
	endtask

	always @(negedge clk) begin
		dout_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (pending_mixes.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual sample %0d lamps %b",
					$time, dout_ch.sample_out, dout_ch.led_mask);
				mismatch_count++;
			end else begin
				want = pending_mixes.pop_front();
				if (dout_ch.sample_out !== want.sample) begin
					$display("%0t: sample_out mismatch: expected %0d actual %0d",
						$time, want.sample, dout_ch.sample_out);
					mismatch_count++;
				end
				if (dout_ch.led_mask !== want.lamps) begin
					$display("%0t: led_mask mismatch: expected %b actual %b",
						$time, want.lamps, dout_ch.led_mask);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)) begin
				stall_cycles <= 0;
			end else if (din_ch.valid || pending_mixes.size() != 0) begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
				$display("selectable_tap_delay_mixer regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		din_ch.valid       = 1'b0;
		din_ch.sample_in   = '0;
		din_ch.mix_level   = '0;
		din_ch.switch_down = 1'b0;
		accepted_count     = 0;
		src_idle_pct       = 17;
		snk_idle_pct       = 54;
		for (int i = 0; i < stdm_pkg::DELAY_DEPTH_DEF; i++) begin
			echo_mem[i] = '0;
		end
		wr_pos    = '0;
		mode_q    = stdm_pkg::MODE_SHORT;
		switch_q  = 1'b0;
		refresh_q = '0;
		lamp_q    = '0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_extremes();
		test_random_stream(530, 17, 54);
		test_random_stream(530, 54, 17);
		test_random_stream(540, 0, 0);

		hold_until_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("selectable_tap_delay_mixer regression: pass");
		end else begin
			$display("selectable_tap_delay_mixer regression: fail");
		end
		$finish;
	end

endmodule
